FILE: hw/rtl/bmm_pkg.sv
// Shared types, codes and helpers for the banked memory mapper.
`default_nettype none

package bmm_pkg;

  // Item operation codes.
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_LOAD  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Source of the byte returned for a bus read.
  typedef enum logic [2:0] {
    SRC_ROM,
    SRC_VRAM,
    SRC_XRAM,
    SRC_WRAM,
    SRC_HRAM,
    SRC_OPEN_BUS
  } src_t;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXT_RAM_FOUR_BANKS  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROM_BANK_COUNT_LOG2 = 1'd1;
  localparam int CFG_DATA_W = 3;

  // Control window (bus writes below 0x8000), selected by address bits 14:13.
  localparam logic [1:0] CTL_RAM_ENABLE = 2'd0;
  localparam logic [1:0] CTL_BANK_LOW   = 2'd1;
  localparam logic [1:0] CTL_BANK_HIGH  = 2'd2;
  localparam logic [1:0] CTL_MODE       = 2'd3;

  // Upper half of the bus, selected by address bits 14:13.
  localparam logic [1:0] AREA_VRAM = 2'd0;
  localparam logic [1:0] AREA_XRAM = 2'd1;
  localparam logic [1:0] AREA_WRAM = 2'd2;
  localparam logic [1:0] AREA_HRAM = 2'd3;

  // Value of the low nibble that enables external RAM.
  localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;
  // Byte returned while external RAM is disabled.
  localparam logic [7:0] OPEN_BUS_BYTE = 8'hFF;

  localparam int ROM_BANK_SEL_W = 7;
  localparam int ROM_OFFSET_W   = 14;
  localparam int RAM_OFFSET_W   = 13;

  // Rebuild the switched ROM bank; a zero low field is read as one.
  function automatic logic [ROM_BANK_SEL_W-1:0] rom_bank_build(input logic [1:0] hi,
                                                               input logic [4:0] lo);
    logic [ROM_BANK_SEL_W-1:0] n;
    begin
      n = {hi, lo};
      if (lo == 5'd0) begin
        n[0] = 1'b1;
      end
      return n;
    end
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/banked_memory_mapper.sv
// Banked memory mapper: cartridge bank controller with ROM and internal RAMs.
// Throughput: one item per cycle unless the result side stalls; a new item is taken
// while a result waits only if the read stage is empty. A bus read passes through the
// synchronous RAM read register and then the output register to reach read_data.
// Reset returns the bank controller and configuration registers to their defaults and
// clears the pipeline valid flags; memory contents are not cleared and are undefined until written.
`default_nettype none

module banked_memory_mapper #(
  parameter int ROM_BANKS     = 128,
  parameter int EXT_RAM_BANKS = 4
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Configuration write channel
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [bmm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [bmm_pkg::CFG_DATA_W-1:0]  cfg_data,
  // Input item channel
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [1:0]                      operation,
  input  wire logic [15:0]                     address,
  input  wire logic [7:0]                      write_data,
  input  wire logic [20:0]                     rom_load_address,
  // Result item channel
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [7:0]                           read_data
);

  import bmm_pkg::*;

  localparam int ROM_BANK_W  = $clog2(ROM_BANKS);
  localparam int ROM_AW      = ROM_BANK_W + ROM_OFFSET_W;
  localparam int XRAM_AW     = $clog2(EXT_RAM_BANKS) + RAM_OFFSET_W;
  localparam int ROM_SEL_N   = 2**ROM_BANK_SEL_W;
  localparam int XRAM_SEL_N  = 4;

  // Configuration registers
  logic       ext_ram_four_banks;
  logic [2:0] rom_bank_count_log2;

  // Bank controller registers
  logic                      ram_enable, ram_enable_next;
  logic [4:0]                bank_low_bits, bank_low_bits_next;
  logic [1:0]                bank_high_bits, bank_high_bits_next;
  logic                      ram_banking_mode, ram_banking_mode_next;
  logic [ROM_BANK_SEL_W-1:0] rom_bank_selected, rom_bank_selected_next;
  logic [1:0]                ram_bank_selected, ram_bank_selected_next;

  // Pipeline control
  logic accept, is_read, is_write, is_load;
  logic s1_valid, s1_advance;
  src_t s1_src, read_src;

  // Address formation
  logic [ROM_BANK_W-1:0]     rom_bank_wrap [ROM_SEL_N];
  logic [1:0]                xram_bank_wrap [XRAM_SEL_N];
  logic [ROM_BANK_SEL_W-1:0] rom_bank_mask;
  logic [ROM_BANK_W-1:0]     switched_bank, read_bank;
  logic [1:0]                xram_bank;
  logic [ROM_AW-1:0]         rom_addr;
  logic [XRAM_AW-1:0]        xram_addr;

  // Memory strobes and read data
  logic rom_we, rom_re, vram_we, vram_re, xram_we, xram_re;
  logic wram_we, wram_re, hram_we, hram_re;
  logic in_upper, in_vram, in_xram, in_wram, in_hram;
  logic [7:0] rom_q, vram_q, xram_q, wram_q, hram_q, out_byte;

  // Configuration writes are taken whenever the block is out of reset.
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      ext_ram_four_banks  <= 1'b1;
      rom_bank_count_log2 <= 3'd7;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_EXT_RAM_FOUR_BANKS:  ext_ram_four_banks  <= cfg_data[0];
        CFG_ROM_BANK_COUNT_LOG2: rom_bank_count_log2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // Item handshake: a new item enters whenever the read stage is empty or can move on.
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !rst && (!s1_valid || s1_advance);
  assign accept     = in_valid && in_ready;
  assign is_read    = accept && (operation == OP_READ);
  assign is_write   = accept && (operation == OP_WRITE);
  assign is_load    = accept && (operation == OP_LOAD);

  // Bank wrap tables: bank number modulo the memory's bank count.
  for (genvar i = 0; i < ROM_SEL_N; i++) begin : g_rom_wrap
    assign rom_bank_wrap[i] = ROM_BANK_W'(i % ROM_BANKS);
  end
  for (genvar i = 0; i < XRAM_SEL_N; i++) begin : g_xram_wrap
    assign xram_bank_wrap[i] = 2'(i % EXT_RAM_BANKS);
  end

  // ROM address: fixed bank, switched bank or the flat load offset.
  assign rom_bank_mask = ROM_BANK_SEL_W'((8'd1 << rom_bank_count_log2) - 8'd1);
  assign switched_bank = rom_bank_wrap[rom_bank_selected & rom_bank_mask];
  assign read_bank     = address[14] ? switched_bank : '0;

  always_comb begin
    if (operation == OP_LOAD) begin
      rom_addr = {rom_bank_wrap[rom_load_address[20:14]], rom_load_address[13:0]};
    end else begin
      rom_addr = {read_bank, address[13:0]};
    end
  end

  // External RAM address with the bank wrapped to the configured size.
  assign xram_bank = ext_ram_four_banks ? xram_bank_wrap[ram_bank_selected] : 2'd0;
  assign xram_addr = XRAM_AW'({xram_bank, address[12:0]});

  // Region decode for the upper half of the bus.
  assign in_upper = address[15];
  assign in_vram  = in_upper && (address[14:13] == AREA_VRAM);
  assign in_xram  = in_upper && (address[14:13] == AREA_XRAM);
  assign in_wram  = in_upper && (address[14:13] == AREA_WRAM);
  assign in_hram  = in_upper && (address[14:13] == AREA_HRAM);

  assign rom_re  = is_read && !in_upper;
  assign rom_we  = is_load;
  assign vram_re = is_read && in_vram;
  assign vram_we = is_write && in_vram;
  assign xram_re = is_read && in_xram && ram_enable;
  assign xram_we = is_write && in_xram && ram_enable;
  assign wram_re = is_read && in_wram;
  assign wram_we = is_write && in_wram;
  assign hram_re = is_read && in_hram;
  assign hram_we = is_write && in_hram;

  // Source of the byte for a read, carried to the output stage.
  always_comb begin
    if (!in_upper) begin
      read_src = SRC_ROM;
    end else begin
      unique case (address[14:13])
        AREA_VRAM: read_src = SRC_VRAM;
        AREA_XRAM: read_src = ram_enable ? SRC_XRAM : SRC_OPEN_BUS;
        AREA_WRAM: read_src = SRC_WRAM;
        AREA_HRAM: read_src = SRC_HRAM;
        default:   read_src = SRC_OPEN_BUS;
      endcase
    end
  end

  // Bank controller: bus writes below 0x8000.
  always_comb begin
    ram_enable_next        = ram_enable;
    bank_low_bits_next     = bank_low_bits;
    bank_high_bits_next    = bank_high_bits;
    ram_banking_mode_next  = ram_banking_mode;
    rom_bank_selected_next = rom_bank_selected;
    ram_bank_selected_next = ram_bank_selected;
    if (is_write && !in_upper) begin
      unique case (address[14:13])
        CTL_RAM_ENABLE: begin
          ram_enable_next = (write_data[3:0] == RAM_ENABLE_KEY);
        end
        CTL_BANK_LOW: begin
          bank_low_bits_next = write_data[4:0];
          if (ram_banking_mode) begin
            bank_high_bits_next = 2'd0;
          end
          rom_bank_selected_next = rom_bank_build(bank_high_bits_next, write_data[4:0]);
        end
        CTL_BANK_HIGH: begin
          if (!ram_banking_mode) begin
            bank_high_bits_next    = write_data[1:0];
            rom_bank_selected_next = rom_bank_build(write_data[1:0], bank_low_bits);
          end else begin
            ram_bank_selected_next = write_data[1:0];
          end
        end
        CTL_MODE: begin
          ram_banking_mode_next = write_data[0];
          if (write_data[0]) begin
            bank_high_bits_next    = 2'd0;
            rom_bank_selected_next = rom_bank_build(2'd0, bank_low_bits);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ram_enable        <= 1'b0;
      bank_low_bits     <= 5'd0;
      bank_high_bits    <= 2'd0;
      ram_banking_mode  <= 1'b0;
      rom_bank_selected <= ROM_BANK_SEL_W'(1);
      ram_bank_selected <= 2'd0;
    end else begin
      ram_enable        <= ram_enable_next;
      bank_low_bits     <= bank_low_bits_next;
      bank_high_bits    <= bank_high_bits_next;
      ram_banking_mode  <= ram_banking_mode_next;
      rom_bank_selected <= rom_bank_selected_next;
      ram_bank_selected <= ram_bank_selected_next;
    end
  end

  // Memories
  bmm_ram #(.AW(ROM_AW)) u_rom (
    .clk(clk), .we(rom_we), .re(rom_re), .addr(rom_addr),
    .wdata(write_data), .rdata(rom_q)
  );

  bmm_ram #(.AW(RAM_OFFSET_W)) u_vram (
    .clk(clk), .we(vram_we), .re(vram_re), .addr(address[12:0]),
    .wdata(write_data), .rdata(vram_q)
  );

  bmm_ram #(.AW(XRAM_AW)) u_xram (
    .clk(clk), .we(xram_we), .re(xram_re), .addr(xram_addr),
    .wdata(write_data), .rdata(xram_q)
  );

  bmm_ram #(.AW(RAM_OFFSET_W)) u_wram (
    .clk(clk), .we(wram_we), .re(wram_re), .addr(address[12:0]),
    .wdata(write_data), .rdata(wram_q)
  );

  bmm_ram #(.AW(RAM_OFFSET_W)) u_hram (
    .clk(clk), .we(hram_we), .re(hram_re), .addr(address[12:0]),
    .wdata(write_data), .rdata(hram_q)
  );

  // Read stage: holds the source while the RAM output register is valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= is_read;
    end
  end

  always_ff @(posedge clk) begin
    if (is_read) begin
      s1_src <= read_src;
    end
  end

  // Pick the byte from the addressed memory.
  always_comb begin
    case (s1_src)
      SRC_ROM:  out_byte = rom_q;
      SRC_VRAM: out_byte = vram_q;
      SRC_XRAM: out_byte = xram_q;
      SRC_WRAM: out_byte = wram_q;
      SRC_HRAM: out_byte = hram_q;
      default:  out_byte = OPEN_BUS_BYTE;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      read_data <= out_byte;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/bmm_ram.sv
// Byte-wide single-port synchronous RAM with a registered read port.
`default_nettype none

module bmm_ram #(
  parameter int AW = 13
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic          re,
  input  wire logic [AW-1:0] addr,
  input  wire logic [7:0]    wdata,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [2**AW];

  // Write and read share the address; only one item touches the RAM per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/bmm_checker.sv
// Port-level assertions for the banked memory mapper, bound to the top level.
`default_nettype none

module bmm_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [1:0] operation,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] read_data
);

  import bmm_pkg::*;

  logic read_taken;
  assign read_taken = in_valid && in_ready && (operation == OP_READ);

  // A stalled result item holds its byte.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data))
    else $error("result item changed while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

  // A result only appears for an accepted read that has passed through the read stage.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(read_taken, 2))
    else $error("result item without a matching read");

  // A read is delivered when the consumer keeps up.
  a_read_latency: assert property (@(posedge clk) disable iff (rst)
    read_taken ##1 out_ready |=> out_valid)
    else $error("read result late");

endmodule

bind banked_memory_mapper bmm_checker u_bmm_checker (.*);

`default_nettype wire

FILE: test/tb.sv
// Self-checking testbench for the banked memory mapper: directed and random bus traffic.
`timescale 1ns / 1ps

module tb;
  import bmm_pkg::*;

  localparam int LIMIT_CYCLES = 300000;
  localparam int DRAIN_CYCLES = 8;
  localparam int IDLE_PERCENT = 33;

  // Places a read can be aimed at.
  typedef enum int {
    RG_ROM_FIXED,
    RG_ROM_SWITCHED,
    RG_VRAM,
    RG_XRAM,
    RG_WRAM_FIXED,
    RG_WRAM_BANKED,
    RG_HRAM,
    RG_COUNT
  } region_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] operation = OP_NONE;
  logic [15:0] address = '0;
  logic [7:0] write_data = '0;
  logic [20:0] rom_load_address = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] read_data;

  // Bank controller state as the mapper should hold it.
  bit ram_enabled = 1'b0;
  logic [4:0] bank_low = '0;
  logic [1:0] bank_high = '0;
  bit ram_mode = 1'b0;
  logic [6:0] rom_bank = 7'd1;
  logic [1:0] ram_bank = '0;
  bit four_ram_banks = 1'b1;
  logic [2:0] rom_size_log2 = 3'd7;

  // Memory contents, and the entries written so far so reads stay on known data.
  logic [7:0] rom_image [int unsigned];
  logic [7:0] vram_image [int unsigned];
  logic [7:0] xram_image [int unsigned];
  logic [7:0] wram_fixed_image [int unsigned];
  logic [7:0] wram_banked_image [int unsigned];
  logic [7:0] hram_image [int unsigned];
  int unsigned rom_loaded [$];
  int unsigned xram_written [$];
  int unsigned vram_written [$];
  int unsigned wram_fixed_written [$];
  int unsigned wram_banked_written [$];
  int unsigned hram_written [$];

  logic [7:0] expected_reads [$];
  logic [7:0] expected_byte;
  bit steady = 1'b0;
  int errors = 0;
  int reads_checked = 0;
  int items_sent = 0;
  int configs_written = 0;
  int cycles = 0;

  banked_memory_mapper dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .address(address),
    .write_data(write_data),
    .rom_load_address(rom_load_address),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .read_data(read_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The result side stalls at random unless a steady stretch is running.
  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // Bank number seen through the switched window after masking to the cartridge size.
  function automatic logic [6:0] switched_rom_bank();
    logic [7:0] mask;
    mask = (8'd1 << rom_size_log2) - 8'd1;
    return rom_bank & mask[6:0];
  endfunction

  // With a single external RAM bank every bank number folds onto bank zero.
  function automatic logic [1:0] active_ram_bank();
    return four_ram_banks ? ram_bank : 2'd0;
  endfunction

  function automatic void rebuild_rom_bank();
    rom_bank = {bank_high, bank_low};
    if (bank_low == 5'd0) begin
      rom_bank = rom_bank + 7'd1;
    end
  endfunction

  function automatic logic [7:0] predict_read(input logic [15:0] a);
    case (a[15:12])
      4'h0, 4'h1, 4'h2, 4'h3: return rom_image[{7'd0, a[13:0]}];
      4'h4, 4'h5, 4'h6, 4'h7: return rom_image[{switched_rom_bank(), a[13:0]}];
      4'h8, 4'h9: return vram_image[a[12:0]];
      4'hA, 4'hB: return ram_enabled ? xram_image[{active_ram_bank(), a[12:0]}] : OPEN_BUS_BYTE;
      4'hC: return wram_fixed_image[a[11:0]];
      4'hD: return wram_banked_image[a[11:0]];
      default: return hram_image[a[12:0]];
    endcase
  endfunction

  // Writes below 0x8000 program the bank controller.
  function automatic void control_write(input logic [15:0] a, input logic [7:0] d);
    case (a[14:13])
      CTL_RAM_ENABLE: ram_enabled = (d[3:0] == RAM_ENABLE_KEY);
      CTL_BANK_LOW: begin
        bank_low = d[4:0];
        if (ram_mode) begin
          bank_high = 2'd0;
        end
        rebuild_rom_bank();
      end
      CTL_BANK_HIGH: begin
        if (!ram_mode) begin
          bank_high = d[1:0];
          rebuild_rom_bank();
        end else begin
          ram_bank = d[1:0];
        end
      end
      default: begin
        ram_mode = d[0];
        if (ram_mode) begin
          bank_high = 2'd0;
          rebuild_rom_bank();
        end
      end
    endcase
  endfunction

  // Update the expected state for one accepted item; reads queue their byte.
  function automatic void apply_item(input op_t op, input logic [15:0] a, input logic [7:0] d,
                                     input logic [20:0] la);
    case (op)
      OP_READ: expected_reads.push_back(predict_read(a));
      OP_WRITE: begin
        case (a[15:12])
          4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7: control_write(a, d);
          4'h8, 4'h9: begin
            vram_image[a[12:0]] = d;
            vram_written.push_back(a[12:0]);
          end
          4'hA, 4'hB: begin
            if (ram_enabled) begin
              xram_image[{active_ram_bank(), a[12:0]}] = d;
              xram_written.push_back({active_ram_bank(), a[12:0]});
            end
          end
          4'hC: begin
            wram_fixed_image[a[11:0]] = d;
            wram_fixed_written.push_back(a[11:0]);
          end
          4'hD: begin
            wram_banked_image[a[11:0]] = d;
            wram_banked_written.push_back(a[11:0]);
          end
          default: begin
            hram_image[a[12:0]] = d;
            hram_written.push_back(a[12:0]);
          end
        endcase
      end
      OP_LOAD: begin
        rom_image[la] = d;
        rom_loaded.push_back(la);
      end
      default: ;
    endcase
  endfunction

  // Choose a read address whose byte is known; returns 0 when nothing readable exists.
  function automatic bit pick_read_address(output logic [15:0] a);
    int unsigned first;
    int unsigned n;
    int unsigned start;
    int unsigned e;
    region_t rg;
    logic [6:0] bank;
    first = $urandom_range(RG_COUNT - 1);
    a = 16'h0000;
    for (int t = 0; t < RG_COUNT; t++) begin
      rg = region_t'((first + t) % RG_COUNT);
      case (rg)
        RG_ROM_FIXED, RG_ROM_SWITCHED: begin
          bank = (rg == RG_ROM_FIXED) ? 7'd0 : switched_rom_bank();
          n = rom_loaded.size();
          start = (n != 0) ? $urandom_range(n - 1) : 0;
          for (int i = 0; i < n; i++) begin
            e = rom_loaded[(start + i) % n];
            if (e[20:14] == bank) begin
              a = {1'b0, rg == RG_ROM_SWITCHED, e[13:0]};
              return 1'b1;
            end
          end
        end
        RG_XRAM: begin
          if (!ram_enabled) begin
            a = {3'b101, 13'($urandom)};
            return 1'b1;
          end
          n = xram_written.size();
          start = (n != 0) ? $urandom_range(n - 1) : 0;
          for (int i = 0; i < n; i++) begin
            e = xram_written[(start + i) % n];
            if (e[14:13] == active_ram_bank()) begin
              a = {3'b101, e[12:0]};
              return 1'b1;
            end
          end
        end
        RG_VRAM: begin
          if (vram_written.size() != 0) begin
            e = vram_written[$urandom_range(vram_written.size() - 1)];
            a = {3'b100, e[12:0]};
            return 1'b1;
          end
        end
        RG_WRAM_FIXED: begin
          if (wram_fixed_written.size() != 0) begin
            e = wram_fixed_written[$urandom_range(wram_fixed_written.size() - 1)];
            a = {4'hC, e[11:0]};
            return 1'b1;
          end
        end
        RG_WRAM_BANKED: begin
          if (wram_banked_written.size() != 0) begin
            e = wram_banked_written[$urandom_range(wram_banked_written.size() - 1)];
            a = {4'hD, e[11:0]};
            return 1'b1;
          end
        end
        RG_HRAM: begin
          if (hram_written.size() != 0) begin
            e = hram_written[$urandom_range(hram_written.size() - 1)];
            a = {3'b111, e[12:0]};
            return 1'b1;
          end
        end
        default: ;
      endcase
    end
    return 1'b0;
  endfunction

  // Offer one item, entered and left at a falling edge; valid stays up between items unless an idle gap is inserted.
  task automatic send_item(input op_t op, input logic [15:0] a, input logic [7:0] d,
                           input logic [20:0] la);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    address <= a;
    write_data <= d;
    rom_load_address <= la;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    apply_item(op, a, d, la);
    if (op != OP_NONE) begin
      items_sent++;
    end
    @(negedge clk);
  endtask

  task automatic bus_read(input logic [15:0] a);
    send_item(OP_READ, a, 8'($urandom), 21'($urandom));
  endtask

  task automatic bus_write(input logic [15:0] a, input logic [7:0] d);
    send_item(OP_WRITE, a, d, 21'($urandom));
  endtask

  task automatic rom_load(input logic [20:0] la, input logic [7:0] d);
    send_item(OP_LOAD, 16'($urandom), d, la);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write.
  task automatic write_config(input logic [CFG_INDEX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    if (idx == CFG_EXT_RAM_FOUR_BANKS) begin
      four_ram_banks = val[0];
    end else begin
      rom_size_log2 = val;
    end
    configs_written++;
    @(negedge clk);
  endtask

  // Drop valid, collect every pending read, then let writes still in flight retire.
  task automatic wait_for_quiet();
    in_valid <= 1'b0;
    while (expected_reads.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic random_read();
    logic [15:0] a;
    if (pick_read_address(a)) begin
      bus_read(a);
    end else begin
      bus_write({3'b100, 13'($urandom)}, 8'($urandom));
    end
  endtask

  task automatic test_reset_state();
    // External RAM is disabled out of reset, so it reads as open bus.
    bus_read(16'hA000);
    // The switched window starts on bank one.
    rom_load(21'h004000, 8'h5A);
    bus_read(16'h4000);
  endtask

  task automatic test_memory_map_edges();
    // First and last bytes of the cartridge and of the fixed bank.
    rom_load(21'h000000, 8'hC3);
    rom_load(21'h003FFF, 8'h3C);
    rom_load(21'h1FFFFF, 8'hA5);
    bus_read(16'h0000);
    bus_read(16'h3FFF);
    // Bottom of video RAM and top of the bus.
    bus_write(16'h8000, 8'h00);
    bus_write(16'hFFFF, 8'hFF);
    bus_read(16'h8000);
    bus_read(16'hFFFF);
  endtask

  task automatic test_bank_control();
    // A zero low field selects bank one even with the upper bits of the byte set.
    bus_write(16'h2000, 8'hE0);
    bus_read(16'h4000);
    // All high and low bits select the last bank of the cartridge.
    bus_write(16'h4000, 8'hFF);
    bus_write(16'h3FFF, 8'hFF);
    bus_read(16'h7FFF);
    // RAM banking mode: the 0x4000 window now picks the external RAM bank.
    bus_write(16'h6000, 8'h01);
    bus_write(16'h5FFF, 8'h03);
    // Only the low nibble of the enable byte matters.
    bus_write(16'h0000, 8'h5A);
    bus_write(16'hA000, 8'h99);
    bus_read(16'hA000);
    // Once disabled, reads give open bus and writes are dropped.
    bus_write(16'h1FFF, 8'h0B);
    bus_read(16'hA000);
    bus_write(16'hA000, 8'h22);
    bus_write(16'h1000, 8'hFA);
    bus_read(16'hA000);
    // The unused operation code does nothing.
    send_item(OP_NONE, 16'hFFFF, 8'hFF, 21'h1FFFFF);
  endtask

  // One configuration setting followed by mixed traffic, mostly well-formed sequences.
  task automatic test_random_traffic(input bit four, input logic [2:0] log2, input int count,
                                     input bit no_gaps);
    int stop;
    int pick;
    logic [13:0] rom_off;
    logic [12:0] ram_off;
    logic [7:0] d;
    logic [20:0] la;
    wait_for_quiet();
    write_config(CFG_EXT_RAM_FOUR_BANKS, CFG_DATA_W'(four));
    write_config(CFG_ROM_BANK_COUNT_LOG2, log2);
    cfg_valid <= 1'b0;
    steady = no_gaps;
    stop = items_sent + count;
    while (items_sent < stop) begin
      pick = $urandom_range(99);
      if (pick < 28) begin
        random_read();
      end else if (pick < 42) begin
        bus_write(16'($urandom_range(16'h8000, 16'hFFFF)), 8'($urandom));
      end else if (pick < 56) begin
        // Loads lean toward the banks that reads can currently reach.
        case ($urandom_range(9))
          0, 1, 2, 3, 4: la = {switched_rom_bank(), 14'($urandom)};
          5, 6: la = {7'd0, 14'($urandom)};
          default: la = 21'($urandom);
        endcase
        rom_load(la, 8'($urandom));
      end else if (pick < 72) begin
        // Bank switch, then fill and read back the newly selected bank.
        bus_write(16'($urandom_range(16'h2000, 16'h3FFF)), 8'($urandom));
        if ($urandom_range(1) == 1) begin
          bus_write(16'($urandom_range(16'h4000, 16'h5FFF)), 8'($urandom));
        end
        if ($urandom_range(3) == 0) begin
          bus_write(16'($urandom_range(16'h6000, 16'h7FFF)), 8'($urandom));
        end
        repeat (2) begin
          rom_off = 14'($urandom);
          rom_load({switched_rom_bank(), rom_off}, 8'($urandom));
          bus_read({2'b01, rom_off});
        end
      end else if (pick < 86) begin
        // External RAM session: optional bank select, enable, write and read back.
        if ($urandom_range(1) == 1) begin
          bus_write(16'($urandom_range(16'h6000, 16'h7FFF)), 8'($urandom));
          bus_write(16'($urandom_range(16'h4000, 16'h5FFF)), 8'($urandom));
        end
        bus_write(16'($urandom_range(16'h1FFF)), {4'($urandom), RAM_ENABLE_KEY});
        repeat ($urandom_range(1, 3)) begin
          ram_off = 13'($urandom);
          bus_write({3'b101, ram_off}, 8'($urandom));
          bus_read({3'b101, ram_off});
        end
        if ($urandom_range(2) == 0) begin
          d = 8'($urandom);
          if (d[3:0] == RAM_ENABLE_KEY) begin
            d[3:0] = 4'h0;
          end
          bus_write(16'($urandom_range(16'h1FFF)), d);
          bus_read({3'b101, 13'($urandom)});
        end
      end else if (pick < 96) begin
        bus_write(16'($urandom_range(16'h7FFF)), 8'($urandom));
      end else begin
        send_item(OP_NONE, 16'($urandom), 8'($urandom), 21'($urandom));
      end
    end
    steady = 1'b0;
  endtask

  // Compare each returned byte with the oldest expected read.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_reads.size() == 0) begin
        $error("read_data: no read pending, actual %02h", read_data);
        errors++;
      end else begin
        expected_byte = expected_reads.pop_front();
        if (read_data !== expected_byte) begin
          $error("read_data: expected %02h actual %02h", expected_byte, read_data);
          errors++;
        end
        reads_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  initial begin
    wait (cycles >= LIMIT_CYCLES);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_memory_map_edges();
    test_bank_control();
    test_random_traffic(1'b1, 3'd7, 450, 1'b0);
    test_random_traffic(1'b0, 3'd1, 250, 1'b0);
    test_random_traffic(1'b1, 3'd0, 200, 1'b0);
    test_random_traffic(1'b0, 3'd7, 250, 1'b1);
    test_random_traffic(1'b1, 3'd3, 250, 1'b0);
    test_random_traffic(1'($urandom), 3'($urandom), 250, 1'b0);
    wait_for_quiet();
    $display("Sent %0d bus and load items; %0d reads checked.", items_sent, reads_checked);
    $display("Covered %0d register writes over six cartridge settings.", configs_written);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
